// ===== rtl/flba_pkg.sv =====
// Shared types and codes for the free-list block allocator.
package flba_pkg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_ALLOC_DEC,
        ST_ALLOC_SPLIT,
        ST_ALLOC_SWEEP,
        ST_ALLOC_FIN,
        ST_FREE_DEC,
        ST_FREE_MERGE,
        ST_FREE_SWEEP,
        ST_FREE_FIN,
        ST_RESTORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       fits;
        logic [6:0] pad;
    } fit_t;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_ZERO_SIZE   = 3'd1;
    localparam logic [2:0] STATUS_NO_FIT      = 3'd2;
    localparam logic [2:0] STATUS_BAD_POINTER = 3'd3;
    localparam logic [2:0] STATUS_BAD_ALIGN   = 3'd4;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;

    localparam logic [1:0] CFG_FIT_STRATEGY  = 2'd0;
    localparam logic [1:0] CFG_REGION_BYTES  = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_ALIGN = 2'd2;

    localparam logic [16:0] SMALLEST_REQUEST = 17'd16;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

endpackage

// ===== rtl/flba_fit.sv =====
// Alignment pad and fit test for one block of the table.
module flba_fit #(
    parameter int HEADER_BYTES = 48,
    parameter int SW           = 17,
    parameter int AW           = 19
) (
    input  logic [AW-1:0]     start,
    input  logic [SW-1:0]     size,
    input  logic [6:0]        amask,
    input  logic [AW-1:0]     need,
    output flba_pkg::fit_t    fit
);

    logic [6:0] base_lo;
    logic [6:0] pad;

    always_comb begin
        base_lo  = start[6:0] + 7'(HEADER_BYTES);
        pad      = (7'd0 - base_lo) & amask;
        fit.pad  = pad;
        fit.fits = AW'(size) >= AW'(HEADER_BYTES) + AW'(pad) + need;
    end

endmodule

// ===== rtl/free_list_block_allocator.sv =====
// Free-list block allocator: block table, sequencer and result register.
//
//  port group   dir  word contents
//  s_*          in   tuser: operation; tdata: request_bytes, alignment, user_offset
//  m_*          out  tdata: status, granted_offset, used_bytes, free_blocks
//  cfg_*        in   register write: fit_strategy, region_bytes, default alignment
//
// Allocate and free each make one pass over the block table to search and
// one pass to rewrite it, both at one row per cycle through the single read
// and single write port of the table memory.
// Reset op and unknown ops skip both passes.
// After aresetn the ST_INIT state writes the initial free block before s_tready rises.
// A finished result waits in the output register; the next word is taken meanwhile.
module free_list_block_allocator #(
    parameter int MAX_BLOCKS      = 64,
    parameter int HEADER_BYTES    = 48,
    parameter int MIN_BLOCK_BYTES = 16,
    parameter int OFFSET_BITS     = 17
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [39:0] s_tdata,   // request_bytes[16:0], alignment[23:17], user_offset[39:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], granted_offset[18:3], used_bytes[35:19],
                                   // free_blocks[42:36]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wr_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = OFFSET_BITS;
    localparam int AW = ((OFFSET_BITS > 17) ? OFFSET_BITS : 17) + 2;
    localparam int RW = SW + 1 + IW;

    localparam logic [CW-1:0] LAST_NONE  = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_BLOCKS);
    localparam logic [AW-1:0] HDR        = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] SPLIT_MIN  = AW'(HEADER_BYTES + MIN_BLOCK_BYTES);
    localparam logic [AW-1:0] REGION_MIN = AW'(HEADER_BYTES + MIN_BLOCK_BYTES);
    localparam logic [AW-1:0] REGION_MAX = AW'(1) << (OFFSET_BITS - 1);

    // block table: {size, free, free-list rank}
    logic [RW-1:0] mem [MAX_BLOCKS];
    logic [RW-1:0] mem_rd_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [RW-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    logic [SW-1:0] rd_size;
    logic          rd_free;
    logic [IW-1:0] rd_rank;
    assign rd_size = mem_rd_reg[RW-1 -: SW];
    assign rd_free = mem_rd_reg[IW];
    assign rd_rank = mem_rd_reg[IW-1:0];

    flba_pkg::state_t state_reg, state_next;

    logic [1:0]    fit_strategy_reg, fit_strategy_next;
    logic [16:0]   region_bytes_reg, region_bytes_next;
    logic [6:0]    dflt_align_reg, dflt_align_next;

    logic [1:0]    op_reg, op_next;
    logic [16:0]   size_reg, size_next;
    logic [6:0]    align_reg, align_next;
    logic [15:0]   off_reg, off_next;
    logic [AW-1:0] need_reg, need_next;
    logic [6:0]    amask_reg, amask_next;
    logic          nf_reg, nf_next;
    logic [CW-1:0] nf_start_reg, nf_start_next;

    logic [CW-1:0] sk_reg, sk_next;
    logic [AW-1:0] start_reg, start_next;

    logic          cand_valid_reg, cand_valid_next;
    logic          cand_hi_reg, cand_hi_next;
    logic [CW-1:0] cand_idx_reg, cand_idx_next;
    logic [AW-1:0] cand_start_reg, cand_start_next;
    logic [SW-1:0] cand_size_reg, cand_size_next;
    logic [IW-1:0] cand_rank_reg, cand_rank_next;
    logic [6:0]    cand_pad_reg, cand_pad_next;
    logic          bfree_reg, bfree_next;

    logic [SW-1:0] prow_size_reg, prow_size_next;
    logic          prow_free_reg, prow_free_next;
    logic [IW-1:0] prow_rank_reg, prow_rank_next;
    logic          pfree_reg, pfree_next;
    logic [SW-1:0] psize_reg, psize_next;
    logic [IW-1:0] prank_reg, prank_next;
    logic          nfree_reg, nfree_next;
    logic [SW-1:0] nsize_reg, nsize_next;
    logic [IW-1:0] nrank_reg, nrank_next;
    logic          next_pend_reg, next_pend_next;

    logic [AW-1:0] part_reg, part_next;
    logic [SW-1:0] rest_reg, rest_next;
    logic          split_reg, split_next;
    logic [AW-1:0] msize_reg, msize_next;
    logic [CW-1:0] mrg_reg, mrg_next;
    logic [1:0]    drop_reg, drop_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fc_reg, fc_next;
    logic [CW-1:0] last_reg, last_next;
    logic [SW-1:0] used_reg, used_next;

    logic [2:0]    status_reg, status_next;
    logic [15:0]   granted_reg, granted_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg, m_tdata_next;

    flba_pkg::fit_t fit;

    flba_fit #(
        .HEADER_BYTES (HEADER_BYTES),
        .SW           (SW),
        .AW           (AW)
    ) u_fit (
        .start (start_reg),
        .size  (rd_size),
        .amask (amask_reg),
        .need  (need_reg),
        .fit   (fit)
    );

    logic [AW-1:0] region_eff;
    logic [6:0]    al_eff;
    logic [16:0]   sz_eff;
    logic          better;
    logic          scan_hi;
    logic [AW-1:0] user_lo;
    logic [AW-1:0] row_end;
    logic [IW-1:0] wrank;
    logic [1:0]    rank_dec;
    logic [CW-1:0] last_tmp;

    always_comb begin
        region_eff = AW'(region_bytes_reg);
        if (region_eff < REGION_MIN) begin
            region_eff = REGION_MIN;
        end
        if (region_eff > REGION_MAX) begin
            region_eff = REGION_MAX;
        end
    end

    always_comb begin
        fit_strategy_next = fit_strategy_reg;
        region_bytes_next = region_bytes_reg;
        dflt_align_next   = dflt_align_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                flba_pkg::CFG_FIT_STRATEGY:  fit_strategy_next = cfg_wr_data[1:0];
                flba_pkg::CFG_REGION_BYTES:  region_bytes_next = cfg_wr_data;
                flba_pkg::CFG_DEFAULT_ALIGN: dflt_align_next = cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        off_next        = off_reg;
        need_next       = need_reg;
        amask_next      = amask_reg;
        nf_next         = nf_reg;
        nf_start_next   = nf_start_reg;
        sk_next         = sk_reg;
        start_next      = start_reg;
        cand_valid_next = cand_valid_reg;
        cand_hi_next    = cand_hi_reg;
        cand_idx_next   = cand_idx_reg;
        cand_start_next = cand_start_reg;
        cand_size_next  = cand_size_reg;
        cand_rank_next  = cand_rank_reg;
        cand_pad_next   = cand_pad_reg;
        bfree_next      = bfree_reg;
        prow_size_next  = prow_size_reg;
        prow_free_next  = prow_free_reg;
        prow_rank_next  = prow_rank_reg;
        pfree_next      = pfree_reg;
        psize_next      = psize_reg;
        prank_next      = prank_reg;
        nfree_next      = nfree_reg;
        nsize_next      = nsize_reg;
        nrank_next      = nrank_reg;
        next_pend_next  = next_pend_reg;
        part_next       = part_reg;
        rest_next       = rest_reg;
        split_next      = split_reg;
        msize_next      = msize_reg;
        mrg_next        = mrg_reg;
        drop_next       = drop_reg;
        count_next      = count_reg;
        fc_next         = fc_reg;
        last_next       = last_reg;
        used_next       = used_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        s_tready        = 1'b0;
        al_eff          = (align_reg == 7'd0) ? dflt_align_reg : align_reg;
        sz_eff          = (size_reg < flba_pkg::SMALLEST_REQUEST) ?
                          flba_pkg::SMALLEST_REQUEST : size_reg;
        scan_hi         = sk_reg >= nf_start_reg;
        user_lo         = start_reg + HDR;
        row_end         = start_reg + AW'(rd_size);
        better          = 1'b0;
        wrank           = rd_rank;
        rank_dec        = 2'd0;
        last_tmp        = last_reg;

        unique case (state_reg)
            flba_pkg::ST_INIT, flba_pkg::ST_RESTORE: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {SW'(region_eff), 1'b1, IW'(0)};
                count_next = CW'(1);
                fc_next    = CW'(1);
                last_next  = LAST_NONE;
                used_next  = '0;
                state_next = (state_reg == flba_pkg::ST_INIT) ?
                             flba_pkg::ST_IDLE : flba_pkg::ST_DONE;
            end

            flba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    size_next    = s_tdata[16:0];
                    align_next   = s_tdata[23:17];
                    off_next     = s_tdata[39:24];
                    status_next  = flba_pkg::STATUS_OK;
                    granted_next = '0;
                    unique case (s_tuser)
                        flba_pkg::OP_ALLOC, flba_pkg::OP_FREE: state_next = flba_pkg::ST_PREP;
                        flba_pkg::OP_RESET: state_next = flba_pkg::ST_RESTORE;
                        default:            state_next = flba_pkg::ST_DONE;
                    endcase
                end
            end

            flba_pkg::ST_PREP: begin
                mem_raddr       = '0;
                sk_next         = '0;
                start_next      = '0;
                cand_valid_next = 1'b0;
                cand_hi_next    = 1'b0;
                pfree_next      = 1'b0;
                nfree_next      = 1'b0;
                next_pend_next  = 1'b0;
                nf_next         = (fit_strategy_reg == flba_pkg::FIT_NEXT) &&
                                  (last_reg != LAST_NONE) &&
                                  ({1'b0, last_reg} + (CW+1)'(1) < {1'b0, count_reg});
                nf_start_next   = last_reg + CW'(1);
                need_next       = AW'(sz_eff) + AW'(al_eff) - AW'(1) + HDR;
                amask_next      = al_eff - 7'd1;
                if (op_reg == flba_pkg::OP_FREE) begin
                    state_next = flba_pkg::ST_SCAN;
                end else if (size_reg == 17'd0) begin
                    status_next = flba_pkg::STATUS_ZERO_SIZE;
                    state_next  = flba_pkg::ST_DONE;
                end else if (al_eff == 7'd0 || (al_eff & (al_eff - 7'd1)) != 7'd0) begin
                    status_next = flba_pkg::STATUS_BAD_ALIGN;
                    state_next  = flba_pkg::ST_DONE;
                end else begin
                    state_next = flba_pkg::ST_SCAN;
                end
            end

            flba_pkg::ST_SCAN: begin
                mem_raddr      = IW'(sk_reg + CW'(1));
                start_next     = row_end;
                prow_size_next = rd_size;
                prow_free_next = rd_free;
                prow_rank_next = rd_rank;
                if (op_reg == flba_pkg::OP_FREE) begin
                    if (next_pend_reg) begin
                        next_pend_next = 1'b0;
                        nfree_next     = rd_free;
                        nsize_next     = rd_size;
                        nrank_next     = rd_rank;
                    end
                    better = !cand_valid_reg && AW'(off_reg) >= user_lo &&
                             AW'(off_reg) < row_end;
                    if (better) begin
                        next_pend_next = 1'b1;
                        pfree_next     = (sk_reg != '0) && prow_free_reg;
                        psize_next     = prow_size_reg;
                        prank_next     = prow_rank_reg;
                    end
                end else begin
                    if (nf_reg) begin
                        // wrap: rows past the last allocated one win over rows before it
                        better = !cand_valid_reg || (!cand_hi_reg && scan_hi);
                    end else if (fit_strategy_reg == flba_pkg::FIT_BEST) begin
                        better = !cand_valid_reg || rd_size < cand_size_reg ||
                                 (rd_size == cand_size_reg && rd_rank < cand_rank_reg);
                    end else begin
                        better = !cand_valid_reg || rd_rank < cand_rank_reg;
                    end
                    better = better && rd_free && fit.fits;
                end
                if (better) begin
                    cand_valid_next = 1'b1;
                    cand_hi_next    = scan_hi;
                    cand_idx_next   = sk_reg;
                    cand_start_next = start_reg;
                    cand_size_next  = rd_size;
                    cand_rank_next  = rd_rank;
                    cand_pad_next   = fit.pad;
                    bfree_next      = rd_free;
                end
                if (sk_reg == count_reg - CW'(1)) begin
                    state_next = (op_reg == flba_pkg::OP_FREE) ?
                                 flba_pkg::ST_FREE_DEC : flba_pkg::ST_ALLOC_DEC;
                end else begin
                    sk_next = sk_reg + CW'(1);
                end
            end

            flba_pkg::ST_ALLOC_DEC: begin
                part_next = AW'(cand_size_reg) - AW'(cand_size_reg) + AW'(sz_eff) +
                            AW'(cand_pad_reg) + HDR;
                if (!cand_valid_reg) begin
                    status_next = flba_pkg::STATUS_NO_FIT;
                    state_next  = flba_pkg::ST_DONE;
                end else begin
                    state_next = flba_pkg::ST_ALLOC_SPLIT;
                end
            end

            flba_pkg::ST_ALLOC_SPLIT: begin
                split_next = (count_reg < COUNT_FULL) &&
                             (AW'(cand_size_reg) >= part_reg + SPLIT_MIN);
                rest_next  = SW'(AW'(cand_size_reg) - part_reg);
                sk_next    = count_reg - CW'(1);
                mem_raddr  = IW'(count_reg - CW'(1));
                state_next = flba_pkg::ST_ALLOC_SWEEP;
            end

            flba_pkg::ST_ALLOC_SWEEP: begin
                // descending so rows above the split can move up one place
                mem_raddr = IW'(sk_reg - CW'(1));
                mem_we    = 1'b1;
                if (rd_free) begin
                    if (split_reg) begin
                        wrank = (rd_rank > cand_rank_reg) ? rd_rank : rd_rank + IW'(1);
                    end else begin
                        wrank = (rd_rank > cand_rank_reg) ? rd_rank - IW'(1) : rd_rank;
                    end
                end
                if (sk_reg == cand_idx_reg) begin
                    mem_waddr = IW'(cand_idx_reg);
                    mem_wdata = {split_reg ? SW'(part_reg) : cand_size_reg, 1'b0, rd_rank};
                end else begin
                    mem_waddr = (split_reg && sk_reg > cand_idx_reg) ?
                                IW'(sk_reg + CW'(1)) : IW'(sk_reg);
                    mem_wdata = {rd_size, rd_free, wrank};
                end
                if (sk_reg == '0) begin
                    state_next = flba_pkg::ST_ALLOC_FIN;
                end else begin
                    sk_next = sk_reg - CW'(1);
                end
            end

            flba_pkg::ST_ALLOC_FIN: begin
                if (split_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(cand_idx_reg + CW'(1));
                    mem_wdata = {rest_reg, 1'b1, IW'(0)};
                end
                count_next   = count_reg + CW'(split_reg);
                fc_next      = split_reg ? fc_reg : fc_reg - CW'(1);
                last_next    = cand_idx_reg;
                used_next    = used_reg + (split_reg ? SW'(part_reg) : cand_size_reg);
                granted_next = 16'(cand_start_reg + HDR + AW'(cand_pad_reg));
                status_next  = flba_pkg::STATUS_OK;
                state_next   = flba_pkg::ST_DONE;
            end

            flba_pkg::ST_FREE_DEC: begin
                msize_next = AW'(cand_size_reg) + (nfree_reg ? AW'(nsize_reg) : AW'(0));
                if (!cand_valid_reg || bfree_reg) begin
                    status_next = flba_pkg::STATUS_BAD_POINTER;
                    state_next  = flba_pkg::ST_DONE;
                end else begin
                    used_next  = used_reg - cand_size_reg;
                    state_next = flba_pkg::ST_FREE_MERGE;
                end
            end

            flba_pkg::ST_FREE_MERGE: begin
                msize_next = msize_reg + (pfree_reg ? AW'(psize_reg) : AW'(0));
                mrg_next   = pfree_reg ? cand_idx_reg - CW'(1) : cand_idx_reg;
                drop_next  = {1'b0, pfree_reg} + {1'b0, nfree_reg};
                sk_next    = '0;
                mem_raddr  = '0;
                state_next = flba_pkg::ST_FREE_SWEEP;
            end

            flba_pkg::ST_FREE_SWEEP: begin
                // ascending so rows above the merge can move down
                mem_raddr = IW'(sk_reg + CW'(1));
                rank_dec  = {1'b0, nfree_reg && nrank_reg < rd_rank} +
                            {1'b0, pfree_reg && prank_reg < rd_rank};
                if (rd_free) begin
                    wrank = rd_rank + IW'(1) - IW'(rank_dec);
                end
                if (sk_reg == mrg_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(mrg_reg);
                    mem_wdata = {SW'(msize_reg), 1'b1, IW'(0)};
                end else if (!(sk_reg > mrg_reg && sk_reg <= mrg_reg + CW'(drop_reg))) begin
                    mem_we    = 1'b1;
                    mem_waddr = (sk_reg > mrg_reg) ? IW'(sk_reg - CW'(drop_reg)) : IW'(sk_reg);
                    mem_wdata = {rd_size, rd_free, wrank};
                end
                if (sk_reg == count_reg - CW'(1)) begin
                    state_next = flba_pkg::ST_FREE_FIN;
                end else begin
                    sk_next = sk_reg + CW'(1);
                end
            end

            flba_pkg::ST_FREE_FIN: begin
                count_next = count_reg - CW'(drop_reg);
                fc_next    = fc_reg + CW'(1) - CW'(drop_reg);
                // mark follows the block it was absorbed into
                if (nfree_reg && last_reg != LAST_NONE && last_reg > cand_idx_reg) begin
                    last_tmp = last_reg - CW'(1);
                end
                if (pfree_reg && last_tmp != LAST_NONE && last_tmp >= cand_idx_reg) begin
                    last_tmp = last_tmp - CW'(1);
                end
                last_next   = last_tmp;
                status_next = flba_pkg::STATUS_OK;
                state_next  = flba_pkg::ST_DONE;
            end

            flba_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, 7'(fc_reg), 17'(used_reg), granted_reg, status_reg};
                    state_next    = flba_pkg::ST_IDLE;
                end
            end

            default: state_next = flba_pkg::ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= flba_pkg::ST_INIT;
            fit_strategy_reg <= flba_pkg::FIT_FIRST;
            region_bytes_reg <= 17'd65536;
            dflt_align_reg   <= 7'd16;
            count_reg        <= CW'(1);
            fc_reg           <= CW'(1);
            last_reg         <= LAST_NONE;
            used_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fit_strategy_reg <= fit_strategy_next;
            region_bytes_reg <= region_bytes_next;
            dflt_align_reg   <= dflt_align_next;
            count_reg        <= count_next;
            fc_reg           <= fc_next;
            last_reg         <= last_next;
            used_reg         <= used_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        align_reg      <= align_next;
        off_reg        <= off_next;
        need_reg       <= need_next;
        amask_reg      <= amask_next;
        nf_reg         <= nf_next;
        nf_start_reg   <= nf_start_next;
        sk_reg         <= sk_next;
        start_reg      <= start_next;
        cand_valid_reg <= cand_valid_next;
        cand_hi_reg    <= cand_hi_next;
        cand_idx_reg   <= cand_idx_next;
        cand_start_reg <= cand_start_next;
        cand_size_reg  <= cand_size_next;
        cand_rank_reg  <= cand_rank_next;
        cand_pad_reg   <= cand_pad_next;
        bfree_reg      <= bfree_next;
        prow_size_reg  <= prow_size_next;
        prow_free_reg  <= prow_free_next;
        prow_rank_reg  <= prow_rank_next;
        pfree_reg      <= pfree_next;
        psize_reg      <= psize_next;
        prank_reg      <= prank_next;
        nfree_reg      <= nfree_next;
        nsize_reg      <= nsize_next;
        nrank_reg      <= nrank_next;
        next_pend_reg  <= next_pend_next;
        part_reg       <= part_next;
        rest_reg       <= rest_next;
        split_reg      <= split_next;
        msize_reg      <= msize_next;
        mrg_reg        <= mrg_next;
        drop_reg       <= drop_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/flba_checker.sv =====
// Port-level checks for the free-list block allocator, bound to the top level.
module flba_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [flba_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [2:0]  status;
    logic [15:0] granted;
    assign status  = m_tdata[2:0];
    assign granted = m_tdata[18:3];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status <= flba_pkg::STATUS_BAD_ALIGN)
        else $error("status code out of range");

    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status != flba_pkg::STATUS_OK |-> granted == 16'd0)
        else $error("offset granted on a failed request");

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
